// ===== sv/gregorian_date_arithmetic_top_assert.svh =====
// Assertion macros shared by the date unit
`ifndef GREGORIAN_DATE_ARITHMETIC_TOP_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define GDA_ASSERT_HOLD(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define GDA_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== sv/gda_pkg.sv =====
package gda_pkg;

   typedef logic [1:0] req_code_type;

   localparam req_code_type REQ_TO_ORDINAL = 2'd0;
   localparam req_code_type REQ_TO_DATE    = 2'd1;
   localparam req_code_type REQ_DAYS_APART = 2'd2;

   localparam logic [11:0] BASE_YEAR         = 12'd1900;
   localparam logic [8:0]  COMMON_LEN        = 9'd365;
   localparam logic [8:0]  LEAP_LEN          = 9'd366;
   localparam logic [9:0]  LEAPS_BEFORE_BASE = 10'd460;
   localparam logic [20:0] DAYS_PER_YEAR     = 21'd365;

   localparam logic [8:0] DAYS_BEFORE_MONTH [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   typedef struct packed {
      logic [3:0] month;
      logic [4:0] day;
      logic       bad;
   } date_split_type;

   // floor(x / 25) for x below 1024, by reciprocal multiplication
   function automatic logic [5:0] div25(input logic [9:0] x);
      logic [20:0] prod;
      prod = 21'(x) * 21'd1311;
      return prod[20:15];
   endfunction

   function automatic logic rem25_zero(input logic [9:0] x);
      logic [10:0] back;
      back = 11'(div25(x)) * 11'd25;
      return back == 11'(x);
   endfunction

   function automatic logic is_leap(input logic [11:0] y);
      logic c4;
      logic c100;
      logic c400;
      c4   = (y[1:0] == 2'b00);
      c100 = c4 && rem25_zero(y[11:2]);
      c400 = (y[3:0] == 4'd0) && rem25_zero({2'b00, y[11:4]});
      return (c4 && !c100) || c400;
   endfunction

   function automatic logic [3:0] clamp_month(input logic [3:0] m);
      logic [3:0] r;
      r = m;
      if (m == 4'd0) r = 4'd1;
      if (m > 4'd12) r = 4'd12;
      return r;
   endfunction

   // days before the first of month m (1..12), leap day included
   function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
      logic [3:0] idx;
      logic [8:0] r;
      idx = m - 4'd1;
      r   = DAYS_BEFORE_MONTH[idx];
      if (m > 4'd2 && leap) r = r + 9'd1;
      return r;
   endfunction

endpackage

// ===== sv/gregorian_date_arithmetic_top.sv =====
// The input register takes a request on its transfer; the result register then takes
// its result, held back while rsp_stall holds a valid result, and drives rsp_valid.
// Throughput: one item per cycle unless rsp_stall holds a result; all date arithmetic
// sits in one combinational pass between the input register and the result register.
// Reset clears only the two valid flags; payload registers are not reset.
module gregorian_date_arithmetic_top
   import gda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_month_a,
   input  logic [4:0]  req_day_a,
   input  logic [11:0] req_year_a,
   input  logic [3:0]  req_month_b,
   input  logic [4:0]  req_day_b,
   input  logic [11:0] req_year_b,
   input  logic [8:0]  req_ordinal_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_ordinal_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [19:0] rsp_days_apart,
   output logic        rsp_bad_input
);

   logic         in_valid_ff, in_valid_in;
   req_code_type type_ff;
   logic [3:0]   month_a_ff, month_b_ff;
   logic [4:0]   day_a_ff, day_b_ff;
   logic [11:0]  year_a_ff, year_b_ff;
   logic [8:0]   ordinal_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [8:0]   ordinal_out_ff, ordinal_out_in;
   logic [3:0]   month_out_ff, month_out_in;
   logic [4:0]   day_out_ff, day_out_in;
   logic [19:0]  days_apart_ff, days_apart_in;
   logic         bad_input_ff, bad_input_in;

   logic         out_ready;
   logic         req_accept;
   logic         rsp_load;

   logic [8:0]   ord_a, ord_b;
   logic [20:0]  num_a, num_b, num_diff;
   date_split_type split;

   gda_date_count u_count_a (
      .month      (month_a_ff),
      .day        (day_a_ff),
      .year       (year_a_ff),
      .ordinal    (ord_a),
      .day_number (num_a)
   );

   gda_date_count u_count_b (
      .month      (month_b_ff),
      .day        (day_b_ff),
      .year       (year_b_ff),
      .ordinal    (ord_b),
      .day_number (num_b)
   );

   gda_ord_split u_split (
      .ordinal (ordinal_ff),
      .year    (year_a_ff),
      .split   (split)
   );

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = in_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = in_valid_ff && out_ready;

   always_comb begin
      in_valid_in  = req_accept || (in_valid_ff && !out_ready);
      rsp_valid_in = out_ready ? in_valid_ff : rsp_valid_ff;
      num_diff     = (num_a > num_b) ? (num_a - num_b) : (num_b - num_a);
      ordinal_out_in = 9'd0;
      month_out_in   = 4'd0;
      day_out_in     = 5'd0;
      days_apart_in  = 20'd0;
      bad_input_in   = 1'b0;
      case (type_ff)
         REQ_TO_ORDINAL: ordinal_out_in = ord_a;
         REQ_TO_DATE: begin
            month_out_in = split.month;
            day_out_in   = split.day;
            bad_input_in = split.bad;
         end
         REQ_DAYS_APART: days_apart_in = num_diff[19:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         type_ff    <= req_type;
         month_a_ff <= req_month_a;
         day_a_ff   <= req_day_a;
         year_a_ff  <= req_year_a;
         month_b_ff <= req_month_b;
         day_b_ff   <= req_day_b;
         year_b_ff  <= req_year_b;
         ordinal_ff <= req_ordinal_in;
      end
      if (rsp_load) begin
         ordinal_out_ff <= ordinal_out_in;
         month_out_ff   <= month_out_in;
         day_out_ff     <= day_out_in;
         days_apart_ff  <= days_apart_in;
         bad_input_ff   <= bad_input_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ordinal_out = ordinal_out_ff;
   assign rsp_month_out   = month_out_ff;
   assign rsp_day_out     = day_out_ff;
   assign rsp_days_apart  = days_apart_ff;
   assign rsp_bad_input   = bad_input_ff;

`include "gregorian_date_arithmetic_top_assert.svh"

   `GDA_ASSERT_NEXT(a_accept_fills, req_valid && !req_stall, in_valid_ff, "accepted item lost")
   `GDA_ASSERT_NEXT(a_advance_shows, in_valid_ff && out_ready, rsp_valid,
      "result not presented")
   `GDA_ASSERT_HOLD(a_bad_clears, !(rsp_valid && rsp_bad_input) || (rsp_month_out == 4'd0
      && rsp_day_out == 5'd0 && rsp_ordinal_out == 9'd0 && rsp_days_apart == 20'd0),
      "bad input with non-zero fields")
   `GDA_ASSERT_HOLD(a_month_day, !(rsp_valid && rsp_month_out != 4'd0)
      || (rsp_day_out != 5'd0 && rsp_month_out <= 4'd12), "month without valid day")

endmodule

// ===== sv/gda_date_count.sv =====
module gda_date_count
   import gda_pkg::*;
(
   input  logic [3:0]  month,
   input  logic [4:0]  day,
   input  logic [11:0] year,
   output logic [8:0]  ordinal,
   output logic [20:0] day_number
);

   logic        leap;
   logic [3:0]  mon;
   logic [11:0] prev;
   logic [11:0] years_since;
   logic [9:0]  leaps_to_prev;
   logic [20:0] start_days;

   always_comb begin
      leap          = is_leap(year);
      mon           = clamp_month(month);
      ordinal       = month_start(mon, leap) + 9'(day);
      prev          = year - 12'd1;
      years_since   = year - BASE_YEAR;
      leaps_to_prev = 10'(prev[11:2]) - 10'(div25(prev[11:2]))
                    + 10'(div25({2'b00, prev[11:4]}));
      if (year > BASE_YEAR) begin
         start_days = 21'(years_since) * DAYS_PER_YEAR + 21'(leaps_to_prev)
                    - 21'(LEAPS_BEFORE_BASE);
      end else begin
         start_days = 21'd0;
      end
      day_number = start_days + 21'(ordinal) - 21'd1;
   end

endmodule

// ===== sv/gda_ord_split.sv =====
module gda_ord_split
   import gda_pkg::*;
(
   input  logic [8:0]     ordinal,
   input  logic [11:0]    year,
   output date_split_type split
);

   logic       leap;
   logic [8:0] len;
   logic [3:0] mon;
   logic [8:0] start;
   logic [8:0] diff;

   always_comb begin
      leap = is_leap(year);
      len  = leap ? LEAP_LEN : COMMON_LEN;
      mon  = 4'd1;
      for (int m = 2; m <= 12; m++) begin
         if (month_start(4'(m), leap) < ordinal) mon = 4'(m);
      end
      start = month_start(mon, leap);
      diff  = ordinal - start;
      split.bad = (ordinal == 9'd0) || (ordinal > len);
      if (split.bad) begin
         split.month = 4'd0;
         split.day   = 5'd0;
      end else begin
         split.month = mon;
         split.day   = diff[4:0];
      end
   end

endmodule
